### design/acld_pkg.sv
// ----------------------------------------------------------------------------
// acld_pkg
// shared types and character codes of the at command line dispatcher
// ----------------------------------------------------------------------------
package acld_pkg;

  localparam logic [7:0] CharA   = 8'h41;
  localparam logic [7:0] CharT   = 8'h54;
  localparam logic [7:0] CharLf  = 8'h0a;
  localparam logic [7:0] CharCr  = 8'h0d;
  localparam logic [7:0] CharEsc = 8'h1b;
  localparam logic [7:0] CharEq  = 8'h3d;
  localparam logic [7:0] CharQm  = 8'h3f;

  typedef enum logic [1:0] {
    OP_RX_CHAR   = 2'd0,
    OP_NAME_CHAR = 2'd1,
    OP_ENTRY     = 2'd2,
    OP_READ_LINE = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    OC_OVERFLOW  = 4'd0,
    OC_NO_AT     = 4'd1,
    OC_BARE_AT   = 4'd2,
    OC_EXEC      = 4'd3,
    OC_HELP      = 4'd4,
    OC_SET       = 4'd5,
    OC_READ      = 4'd6,
    OC_UNMATCHED = 4'd7,
    OC_BYTE      = 4'd8
  } outcome_e;

  typedef enum logic [2:0] {
    LS_INDEX,
    LS_ZERO,
    LS_ONE,
    LS_K,
    LS_CL,
    LS_CL1
  } line_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE,
    ST_CHK_LEN,
    ST_CHK_A,
    ST_CHK_T,
    ST_ENTRY,
    ST_ENTRY_W,
    ST_CMP,
    ST_CMP_W,
    ST_FORM,
    ST_FORM_W,
    ST_HELP_W,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic      accept;
    line_sel_e line_sel;
    logic      i_clr;
    logic      i_inc;
    logic      k_clr;
    logic      k_inc;
    logic      res_load;
    outcome_e  res_code;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    opcode_e    opcode;
    logic       is_lf;
    logic       ovf;
    logic       len_zero;
    logic       cls_lt2;
    logic       cls_eq2;
    logic [7:0] line_data;
    logic       name_eq;
    logic       i_done;
    logic       rest_lt_nl;
    logic       k_done;
    logic       cl_eq_rest;
    logic       cl1_eq_rest;
    logic       cl2_eq_rest;
    logic [3:0] flags;
  } status_t;

endpackage

### design/acld_ram.sv
// ----------------------------------------------------------------------------
// acld_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module acld_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/acld_ctrl.sv
// ----------------------------------------------------------------------------
// acld_ctrl
// sequencer: line collection, classification walk and result handoff
// ----------------------------------------------------------------------------
module acld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  acld_pkg::status_t st_i,
  output acld_pkg::cmd_t    cmd_o
);

  acld_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acld_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.line_sel   = acld_pkg::LS_INDEX;
    cmd_o.res_code   = acld_pkg::OC_UNMATCHED;
    case (state_q)
      acld_pkg::ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (st_i.opcode == acld_pkg::OP_READ_LINE) begin
            state_d = acld_pkg::ST_BYTE;
          end else if (st_i.opcode == acld_pkg::OP_RX_CHAR && st_i.is_lf) begin
            if (st_i.ovf) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = acld_pkg::OC_OVERFLOW;
              state_d        = acld_pkg::ST_EMIT;
            end else if (!st_i.len_zero) begin
              state_d = acld_pkg::ST_CHK_LEN;
            end
          end
        end
      end
      acld_pkg::ST_BYTE: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = acld_pkg::OC_BYTE;
        state_d        = acld_pkg::ST_EMIT;
      end
      acld_pkg::ST_CHK_LEN: begin
        cmd_o.line_sel = acld_pkg::LS_ZERO;
        if (st_i.cls_lt2) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = acld_pkg::OC_NO_AT;
          state_d        = acld_pkg::ST_EMIT;
        end else begin
          state_d = acld_pkg::ST_CHK_A;
        end
      end
      acld_pkg::ST_CHK_A: begin
        cmd_o.line_sel = acld_pkg::LS_ONE;
        if (st_i.line_data != acld_pkg::CharA) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = acld_pkg::OC_NO_AT;
          state_d        = acld_pkg::ST_EMIT;
        end else begin
          state_d = acld_pkg::ST_CHK_T;
        end
      end
      acld_pkg::ST_CHK_T: begin
        if (st_i.line_data != acld_pkg::CharT) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = acld_pkg::OC_NO_AT;
          state_d        = acld_pkg::ST_EMIT;
        end else if (st_i.cls_eq2) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = acld_pkg::OC_BARE_AT;
          state_d        = acld_pkg::ST_EMIT;
        end else begin
          cmd_o.i_clr = 1'b1;
          state_d     = acld_pkg::ST_ENTRY;
        end
      end
      acld_pkg::ST_ENTRY: begin
        if (st_i.i_done) begin
          cmd_o.res_load = 1'b1;
          state_d        = acld_pkg::ST_EMIT;
        end else begin
          state_d = acld_pkg::ST_ENTRY_W;
        end
      end
      acld_pkg::ST_ENTRY_W: begin
        if (st_i.rest_lt_nl) begin
          cmd_o.i_inc = 1'b1;
          state_d     = acld_pkg::ST_ENTRY;
        end else begin
          cmd_o.k_clr = 1'b1;
          state_d     = acld_pkg::ST_CMP;
        end
      end
      acld_pkg::ST_CMP: begin
        cmd_o.line_sel = acld_pkg::LS_K;
        state_d = st_i.k_done ? acld_pkg::ST_FORM : acld_pkg::ST_CMP_W;
      end
      acld_pkg::ST_CMP_W: begin
        cmd_o.line_sel = acld_pkg::LS_K;
        if (!st_i.name_eq) begin
          cmd_o.i_inc = 1'b1;
          state_d     = acld_pkg::ST_ENTRY;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = acld_pkg::ST_CMP;
        end
      end
      acld_pkg::ST_FORM: begin
        cmd_o.line_sel = acld_pkg::LS_CL;
        if (st_i.cl_eq_rest) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = st_i.flags[0] ? acld_pkg::OC_EXEC : acld_pkg::OC_UNMATCHED;
          state_d        = acld_pkg::ST_EMIT;
        end else begin
          state_d = acld_pkg::ST_FORM_W;
        end
      end
      acld_pkg::ST_FORM_W: begin
        cmd_o.line_sel = acld_pkg::LS_CL1;
        cmd_o.res_load = 1'b1;
        state_d        = acld_pkg::ST_EMIT;
        if (st_i.line_data == acld_pkg::CharEq) begin
          if (st_i.cl2_eq_rest) begin
            cmd_o.res_load = 1'b0;
            state_d        = acld_pkg::ST_HELP_W;
          end else if (st_i.flags[2]) begin
            cmd_o.res_code = acld_pkg::OC_SET;
          end
        end else if (st_i.line_data == acld_pkg::CharQm && st_i.cl1_eq_rest
                     && st_i.flags[3]) begin
          cmd_o.res_code = acld_pkg::OC_READ;
        end
      end
      acld_pkg::ST_HELP_W: begin
        cmd_o.res_load = 1'b1;
        state_d        = acld_pkg::ST_EMIT;
        if (st_i.line_data == acld_pkg::CharQm && st_i.flags[1]) begin
          cmd_o.res_code = acld_pkg::OC_HELP;
        end else if (st_i.flags[2]) begin
          cmd_o.res_code = acld_pkg::OC_SET;
        end
      end
      acld_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = acld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = acld_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  assign in_stall_o  = (state_q != acld_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/acld_dp.sv
// ----------------------------------------------------------------------------
// acld_dp
// datapath: line store, command table, walk counters, config and result
// ----------------------------------------------------------------------------
module acld_dp #(
  parameter int LINE_DEPTH   = 256,
  parameter int MAX_COMMANDS = 16,
  parameter int NAME_MAX     = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acld_pkg::cmd_t    cmd_i,
  output acld_pkg::status_t st_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        char_value_i,
  input  logic [3:0]        entry_index_i,
  input  logic [3:0]        char_position_i,
  input  logic [4:0]        name_length_i,
  input  logic [3:0]        handler_flags_i,
  input  logic [7:0]        line_index_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic [3:0]        outcome_o,
  output logic [3:0]        command_index_o,
  output logic [7:0]        param_start_o,
  output logic [7:0]        param_length_o,
  output logic [7:0]        line_byte_o
);

  localparam int LAW = $clog2(LINE_DEPTH);
  localparam int CW  = $clog2(MAX_COMMANDS + 1);
  localparam int IW  = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
  localparam int NW  = $clog2(NAME_MAX);
  localparam int NLW = $clog2(NAME_MAX + 1);
  localparam int IFW = NLW + 4;

  logic [4:0]     cc_q;
  logic [LAW-1:0] len_q, cls_len_q;
  logic           ovf_q, idx_ok_q;
  logic [CW-1:0]  i_q;
  logic [NLW-1:0] k_q, cl_q;
  logic [3:0]     flags_q;

  logic [3:0] res_oc_q, res_idx_q;
  logic [7:0] res_ps_q, res_pl_q, res_byte_q;
  logic [3:0] out_oc_q, out_idx_q;
  logic [7:0] out_ps_q, out_pl_q, out_byte_q;

  logic           is_char, is_lf, is_cr, is_esc;
  logic [31:0]    rest32, cl32, k32, cnt32, nl32;
  logic [LAW-1:0] line_raddr;
  logic [7:0]     line_rdata, name_rdata;
  logic [IFW-1:0] info_rdata, info_wdata;
  logic           line_we, name_we, info_we;
  logic [31:0]    e32, p32, nlen32, li32;
  logic [NLW-1:0] nlen_sat;

  assign is_char = cmd_i.accept && opcode_i == acld_pkg::OP_RX_CHAR;
  assign is_lf   = char_value_i == acld_pkg::CharLf;
  assign is_cr   = char_value_i == acld_pkg::CharCr;
  assign is_esc  = char_value_i == acld_pkg::CharEsc;

  assign e32    = 32'(entry_index_i);
  assign p32    = 32'(char_position_i);
  assign nlen32 = 32'(name_length_i);
  assign li32   = 32'(line_index_i);
  assign nlen_sat = (nlen32 > NAME_MAX) ? NLW'(NAME_MAX) : name_length_i[NLW-1:0];

  assign line_we = is_char && !is_lf && !is_cr && !is_esc
                   && (32'(len_q) < LINE_DEPTH - 1) && !ovf_q;
  assign name_we = cmd_i.accept && opcode_i == acld_pkg::OP_NAME_CHAR
                   && e32 < MAX_COMMANDS && p32 < NAME_MAX;
  assign info_we = cmd_i.accept && opcode_i == acld_pkg::OP_ENTRY
                   && e32 < MAX_COMMANDS;
  assign info_wdata = {nlen_sat, handler_flags_i};

  always_comb begin
    case (cmd_i.line_sel)
      acld_pkg::LS_ZERO: line_raddr = '0;
      acld_pkg::LS_ONE:  line_raddr = LAW'(1);
      acld_pkg::LS_K:    line_raddr = LAW'(k32 + 32'd2);
      acld_pkg::LS_CL:   line_raddr = LAW'(cl32 + 32'd2);
      acld_pkg::LS_CL1:  line_raddr = LAW'(cl32 + 32'd3);
      default:           line_raddr = li32[LAW-1:0];
    endcase
  end

  acld_ram #(.Width(8), .Depth(LINE_DEPTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (len_q),
    .wdata_i (char_value_i),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  acld_ram #(.Width(8), .Depth(2 ** (IW + NW))) u_name (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i ({e32[IW-1:0], p32[NW-1:0]}),
    .wdata_i (char_value_i),
    .raddr_i ({i_q[IW-1:0], k_q[NW-1:0]}),
    .rdata_o (name_rdata)
  );

  acld_ram #(.Width(IFW), .Depth(2 ** IW)) u_info (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (e32[IW-1:0]),
    .wdata_i (info_wdata),
    .raddr_i (i_q[IW-1:0]),
    .rdata_o (info_rdata)
  );

  assign rest32 = 32'(cls_len_q) - 32'd2;
  assign cl32   = 32'(cl_q);
  assign k32    = 32'(k_q);
  assign nl32   = 32'(info_rdata[IFW-1:4]);
  assign cnt32  = (32'(cc_q) > MAX_COMMANDS) ? MAX_COMMANDS : 32'(cc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q  <= '0;
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        cc_q <= pwdata[4:0];
      end
      if (is_char) begin
        if (is_lf || is_esc) begin
          len_q <= '0;
          ovf_q <= 1'b0;
        end else if (!is_cr) begin
          if (32'(len_q) >= LINE_DEPTH - 1) begin
            ovf_q <= 1'b1;
          end else if (!ovf_q) begin
            len_q <= len_q + LAW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cls_len_q <= len_q;
      idx_ok_q  <= li32 < LINE_DEPTH;
    end
    if (cmd_i.i_clr) begin
      i_q <= '0;
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.k_clr) begin
      k_q     <= '0;
      cl_q    <= info_rdata[IFW-1:4];
      flags_q <= info_rdata[3:0];
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + NLW'(1);
    end
    if (cmd_i.res_load) begin
      res_oc_q   <= cmd_i.res_code;
      res_idx_q  <= '0;
      res_ps_q   <= '0;
      res_pl_q   <= '0;
      res_byte_q <= '0;
      if (cmd_i.res_code == acld_pkg::OC_EXEC || cmd_i.res_code == acld_pkg::OC_HELP
          || cmd_i.res_code == acld_pkg::OC_SET || cmd_i.res_code == acld_pkg::OC_READ) begin
        res_idx_q <= 4'(i_q);
      end
      if (cmd_i.res_code == acld_pkg::OC_SET) begin
        res_ps_q <= 8'(cl32 + 32'd3);
        res_pl_q <= 8'(rest32 - cl32 - 32'd1);
      end
      if (cmd_i.res_code == acld_pkg::OC_BYTE && idx_ok_q) begin
        res_byte_q <= line_rdata;
      end
    end
    if (cmd_i.out_load) begin
      out_oc_q   <= res_oc_q;
      out_idx_q  <= res_idx_q;
      out_ps_q   <= res_ps_q;
      out_pl_q   <= res_pl_q;
      out_byte_q <= res_byte_q;
    end
  end

  always_comb begin
    st_o             = '0;
    st_o.opcode      = acld_pkg::opcode_e'(opcode_i);
    st_o.is_lf       = is_lf;
    st_o.ovf         = ovf_q;
    st_o.len_zero    = len_q == '0;
    st_o.cls_lt2     = 32'(cls_len_q) < 32'd2;
    st_o.cls_eq2     = 32'(cls_len_q) == 32'd2;
    st_o.line_data   = line_rdata;
    st_o.name_eq     = line_rdata == name_rdata;
    st_o.i_done      = 32'(i_q) >= cnt32;
    st_o.rest_lt_nl  = rest32 < nl32;
    st_o.k_done      = k_q == cl_q;
    st_o.cl_eq_rest  = cl32 == rest32;
    st_o.cl1_eq_rest = cl32 + 32'd1 == rest32;
    st_o.cl2_eq_rest = cl32 + 32'd2 == rest32;
    st_o.flags       = flags_q;
  end

  assign prdata          = paddr[2] ? 32'd0 : 32'(cc_q);
  assign outcome_o       = out_oc_q;
  assign command_index_o = out_idx_q;
  assign param_start_o   = out_ps_q;
  assign param_length_o  = out_pl_q;
  assign line_byte_o     = out_byte_q;

endmodule

### design/at_command_line_dispatcher.sv
// ----------------------------------------------------------------------------
// at_command_line_dispatcher
// collects received characters into a line and classifies it on line feed
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/stall_o   | opcode, char, table and line fields
//  out     | output    | out_valid_o/stall_i  | outcome, index, param span, byte
//  config  | input     | apb psel/penable     | command_count at address 0
//
//  characters and table writes are taken in idle, a line byte read passes the
//  byte and emit states; line end walks the table entry by entry and compares
//  names char by char, bounded by the registered read of the line and name rams
//  reset clears line length, overflow and the command count; tables persist
//  a waiting result holds the next result and stalls requests behind that result
// ----------------------------------------------------------------------------
module at_command_line_dispatcher #(
  parameter int LINE_DEPTH   = 256,
  parameter int MAX_COMMANDS = 16,
  parameter int NAME_MAX     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_value_i,
  input  logic [3:0]  entry_index_i,
  input  logic [3:0]  char_position_i,
  input  logic [4:0]  name_length_i,
  input  logic [3:0]  handler_flags_i,
  input  logic [7:0]  line_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  outcome_o,
  output logic [3:0]  command_index_o,
  output logic [7:0]  param_start_o,
  output logic [7:0]  param_length_o,
  output logic [7:0]  line_byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  acld_pkg::cmd_t    cmd;
  acld_pkg::status_t st;

  assign pready = 1'b1;

  acld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  acld_dp #(
    .LINE_DEPTH   (LINE_DEPTH),
    .MAX_COMMANDS (MAX_COMMANDS),
    .NAME_MAX     (NAME_MAX)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .opcode_i        (opcode_i),
    .char_value_i    (char_value_i),
    .entry_index_i   (entry_index_i),
    .char_position_i (char_position_i),
    .name_length_i   (name_length_i),
    .handler_flags_i (handler_flags_i),
    .line_index_i    (line_index_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .outcome_o       (outcome_o),
    .command_index_o (command_index_o),
    .param_start_o   (param_start_o),
    .param_length_o  (param_length_o),
    .line_byte_o     (line_byte_o)
  );

endmodule

### tb/at_command_line_dispatcher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_command_line_dispatcher_checker
// watches the request and result channels, keeps its own copy of the line
// buffer and command table, predicts each result and compares field by field
// ----------------------------------------------------------------------------
module at_command_line_dispatcher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_value_i,
  input  logic [3:0]  entry_index_i,
  input  logic [3:0]  char_position_i,
  input  logic [4:0]  name_length_i,
  input  logic [3:0]  handler_flags_i,
  input  logic [7:0]  line_index_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  outcome_i,
  input  logic [3:0]  command_index_i,
  input  logic [7:0]  param_start_i,
  input  logic [7:0]  param_length_i,
  input  logic [7:0]  line_byte_i,
  input  logic        cfg_write_i,
  input  logic [4:0]  cfg_count_i,
  output int          error_count_o,
  output int          pending_o
);

  typedef struct packed {
    acld_pkg::outcome_e outcome;
    logic [3:0]         cmd_idx;
    logic [7:0]         pstart;
    logic [7:0]         plen;
    logic [7:0]         lbyte;
  } verdict_t;

  verdict_t   verdict_q[$];
  logic [7:0] line_buf[256];
  logic [8:0] line_len;
  logic       line_ovf;
  logic [7:0] names[16][16];
  logic [4:0] name_len[16];
  logic [3:0] flags_tbl[16];
  logic [4:0] cmd_count;

  assign pending_o = verdict_q.size();

  function automatic verdict_t mk(acld_pkg::outcome_e oc, int idx = 0, int ps = 0,
                                  int pl = 0);
    verdict_t v;
    v.outcome = oc;
    v.cmd_idx = idx[3:0];
    v.pstart  = ps[7:0];
    v.plen    = pl[7:0];
    v.lbyte   = '0;
    return v;
  endfunction

  function automatic verdict_t classify_line();
    int rest, cnt, cl;
    logic [3:0] fl;
    bit same;
    if (line_len < 2 || line_buf[0] != acld_pkg::CharA || line_buf[1] != acld_pkg::CharT)
      return mk(acld_pkg::OC_NO_AT);
    if (line_len == 2) return mk(acld_pkg::OC_BARE_AT);
    rest = line_len - 2;
    cnt = cmd_count > 16 ? 16 : cmd_count;
    for (int i = 0; i < cnt; i++) begin
      cl = name_len[i];
      fl = flags_tbl[i];
      if (rest < cl) continue;
      same = 1;
      for (int k = 0; k < cl; k++) if (line_buf[2 + k] != names[i][k]) same = 0;
      if (!same) continue;
      if (cl == rest) begin
        if (fl[0]) return mk(acld_pkg::OC_EXEC, i);
      end else if (line_buf[2 + cl] == acld_pkg::CharEq) begin
        if (cl + 2 == rest && line_buf[3 + cl] == acld_pkg::CharQm && fl[1])
          return mk(acld_pkg::OC_HELP, i);
        if (fl[2]) return mk(acld_pkg::OC_SET, i, 3 + cl, rest - cl - 1);
      end else if (line_buf[2 + cl] == acld_pkg::CharQm && cl + 1 == rest) begin
        if (fl[3]) return mk(acld_pkg::OC_READ, i);
      end
      break;
    end
    return mk(acld_pkg::OC_UNMATCHED);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count_o++;
  endtask

  task automatic take_request();
    verdict_t v;
    case (acld_pkg::opcode_e'(opcode_i))
      acld_pkg::OP_NAME_CHAR: names[entry_index_i][char_position_i] = char_value_i;
      acld_pkg::OP_ENTRY: begin
        name_len[entry_index_i]  = name_length_i > 16 ? 5'd16 : name_length_i;
        flags_tbl[entry_index_i] = handler_flags_i;
      end
      acld_pkg::OP_READ_LINE: begin
        v = mk(acld_pkg::OC_BYTE);
        v.lbyte = line_buf[line_index_i];
        verdict_q.push_back(v);
      end
      default: begin
        if (char_value_i == acld_pkg::CharLf) begin
          if (line_ovf) verdict_q.push_back(mk(acld_pkg::OC_OVERFLOW));
          else if (line_len > 0) verdict_q.push_back(classify_line());
          line_len = 0;
          line_ovf = 0;
        end else if (char_value_i == acld_pkg::CharEsc) begin
          line_len = 0;
          line_ovf = 0;
        end else if (char_value_i != acld_pkg::CharCr) begin
          if (line_len >= 255) line_ovf = 1;
          else if (!line_ovf) begin
            line_buf[line_len] = char_value_i;
            line_len++;
          end
        end
      end
    endcase
  endtask

  task automatic check_result();
    verdict_t v;
    if (verdict_q.size() == 0) begin
      report_mismatch("unexpected result outcome", outcome_i, -1);
      return;
    end
    v = verdict_q.pop_front();
    if (outcome_i != v.outcome) report_mismatch("outcome", outcome_i, v.outcome);
    if (command_index_i != v.cmd_idx) report_mismatch("command_index", command_index_i, v.cmd_idx);
    if (param_start_i != v.pstart) report_mismatch("param_start", param_start_i, v.pstart);
    if (param_length_i != v.plen) report_mismatch("param_length", param_length_i, v.plen);
    if (line_byte_i != v.lbyte) report_mismatch("line_byte", line_byte_i, v.lbyte);
  endtask

  initial begin
    error_count_o = 0;
    line_len = 0;
    line_ovf = 0;
    cmd_count = 0;
    foreach (line_buf[i]) line_buf[i] = '0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len = 0;
      line_ovf = 0;
      cmd_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) take_request();
      if (cfg_write_i) cmd_count = cfg_count_i;
    end
  end

endmodule

### tb/at_command_line_dispatcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_command_line_dispatcher_test
// drives table loads, directed and random command lines, line byte reads and
// command count writes under varying idle patterns; checker compares results
// ----------------------------------------------------------------------------
module at_command_line_dispatcher_test;

  localparam int IdleLimit = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  opcode = acld_pkg::OP_RX_CHAR;
  logic [7:0]  char_value = '0;
  logic [3:0]  entry_index = '0;
  logic [3:0]  char_position = '0;
  logic [4:0]  name_length = '0;
  logic [3:0]  handler_flags = '0;
  logic [7:0]  line_index = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [3:0]  outcome;
  logic [3:0]  command_index;
  logic [7:0]  param_start;
  logic [7:0]  param_length;
  logic [7:0]  line_byte;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          error_count;
  int          pending;
  int          send_idle_pct = 27;
  int          recv_idle_pct = 64;
  bit          hold_off = 0;
  int          idle_cycles = 0;
  int          line_len_now = 0;

  always #1 clk = ~clk;

  at_command_line_dispatcher dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .char_value_i(char_value), .entry_index_i(entry_index),
    .char_position_i(char_position), .name_length_i(name_length),
    .handler_flags_i(handler_flags), .line_index_i(line_index),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .outcome_o(outcome),
    .command_index_o(command_index), .param_start_o(param_start),
    .param_length_o(param_length), .line_byte_o(line_byte),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  at_command_line_dispatcher_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .char_value_i(char_value), .entry_index_i(entry_index),
    .char_position_i(char_position), .name_length_i(name_length),
    .handler_flags_i(handler_flags), .line_index_i(line_index),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .outcome_i(outcome),
    .command_index_i(command_index), .param_start_i(param_start),
    .param_length_i(param_length), .line_byte_i(line_byte),
    .cfg_write_i(psel && penable && pwrite && pready), .cfg_count_i(pwdata[4:0]),
    .error_count_o(error_count), .pending_o(pending)
  );

  // receiver stall
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(acld_pkg::opcode_e op, logic [7:0] ch = 0, logic [3:0] ent = 0,
                      logic [3:0] pos = 0, logic [4:0] nl = 0, logic [3:0] fl = 0,
                      logic [7:0] li = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    char_value    <= ch;
    entry_index   <= ent;
    char_position <= pos;
    name_length   <= nl;
    handler_flags <= fl;
    line_index    <= li;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == acld_pkg::OP_RX_CHAR) begin
      if (ch == acld_pkg::CharLf || ch == acld_pkg::CharEsc) line_len_now = 0;
      else if (ch != acld_pkg::CharCr && line_len_now < 255) line_len_now++;
    end
  endtask

  task automatic rx(logic [7:0] ch);
    send(acld_pkg::OP_RX_CHAR, ch);
  endtask

  task automatic rx_text(string s);
    foreach (s[i]) rx(s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_count(logic [4:0] cnt);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {27'd0, cnt};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_entry(int ent, string nm, logic [3:0] fl, int nl = -1);
    foreach (nm[i]) send(acld_pkg::OP_NAME_CHAR, nm[i], ent[3:0], i[3:0]);
    send(acld_pkg::OP_ENTRY, 0, ent[3:0], 0, nl < 0 ? 5'(nm.len()) : 5'(nl), fl);
  endtask

  task automatic random_line();
    int kind, n;
    kind = $urandom_range(9);
    if (kind < 7) begin
      rx(acld_pkg::CharA); rx(acld_pkg::CharT);
      n = $urandom_range(3);
      if (n > 0) rx_text(n == 1 ? "+X" : (n == 2 ? "+GO" : "$LONGNAME1234567"));
      case ($urandom_range(4))
        0: ;
        1: begin rx(acld_pkg::CharEq); rx(acld_pkg::CharQm); end
        2: begin
          rx(acld_pkg::CharEq);
          repeat ($urandom_range(6)) rx(8'($urandom_range(32, 126)));
        end
        3: rx(acld_pkg::CharQm);
        default: repeat ($urandom_range(1, 3)) rx(8'($urandom_range(255)));
      endcase
      if ($urandom_range(19) == 0) rx(acld_pkg::CharCr);
      if ($urandom_range(29) == 0) rx(acld_pkg::CharEsc);
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 5)) rx(8'($urandom_range(255)));
    end else begin
      send(acld_pkg::OP_READ_LINE, 0, 0, 0, 0, 0,
           8'($urandom_range(0, line_len_now > 0 ? line_len_now - 1 : 0)));
      if (line_len_now == 0) rx(acld_pkg::CharA);
      return;
    end
    rx(acld_pkg::CharLf);
    if (line_len_now == 0 && $urandom_range(3) == 0) rx(acld_pkg::CharLf);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // command table; entry 2 uses a full-length name with a saturated length, the last entry a full-length name
    load_entry(0, "+X", 4'b1111);
    load_entry(1, "+GO", 4'b0101);
    load_entry(2, "$LONGNAME1234567", 4'b1000, 31);
    for (int e = 3; e < 16; e++) load_entry(e, "+Z", 4'($urandom_range(15)));
    for (int p = 0; p < 16; p++) send(acld_pkg::OP_NAME_CHAR, 8'hff, 4'd15, 4'(p));
    send(acld_pkg::OP_ENTRY, 0, 4'd15, 0, 5'd16, 4'b0000);

    set_count(5'd16);
    rx(acld_pkg::CharLf);
    rx_text("AT"); rx(acld_pkg::CharLf);
    rx_text("XY"); rx(acld_pkg::CharLf);
    rx_text("AT+X"); rx(acld_pkg::CharLf);
    rx_text("AT+X=?"); rx(acld_pkg::CharLf);
    rx_text("AT+X=12"); rx(acld_pkg::CharLf);
    rx_text("AT+X?"); rx(acld_pkg::CharLf);
    rx_text("AT+GO=?"); rx(acld_pkg::CharLf);
    rx_text("AT+GO?"); rx(acld_pkg::CharLf);
    rx_text("AT+Q"); rx(acld_pkg::CharCr); rx(acld_pkg::CharLf);
    rx_text("AT$LONGNAME1234567?"); rx(acld_pkg::CharLf);
    rx_text("ATJUNK"); rx(acld_pkg::CharEsc); rx(acld_pkg::CharLf);
    send(acld_pkg::OP_READ_LINE, 0, 0, 0, 0, 0, 8'd0);
    repeat (300) rx(8'h00);
    rx(acld_pkg::CharLf);
    repeat (255) rx(8'hff);
    send(acld_pkg::OP_READ_LINE, 0, 0, 0, 0, 0, 8'd254);
    rx(acld_pkg::CharLf);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 27 : (phase == 1 ? 64 : 0);
      recv_idle_pct = phase == 0 ? 64 : (phase == 1 ? 27 : 0);
      set_count(phase == 0 ? 5'd0 : (phase == 1 ? 5'd31 : 5'd3));
      for (int n = 0; n < 28; n++) begin
        if (phase == 1 && n == 10) begin
          hold_off = 1;
          fork
            begin repeat (3000) @(posedge clk); hold_off = 0; end
          join_none
        end
        random_line();
      end
    end

    drain();
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
